FILE: design/polygon_split_by_line_defines.svh
// Assertion helpers for the top-level design file.
`ifndef POLYGON_SPLIT_BY_LINE_DEFINES_SVH
`define POLYGON_SPLIT_BY_LINE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define PSL_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define PSL_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/psl_pkg.sv
package psl_pkg;

  localparam int unsigned PSL_COORD_BITS = 24;
  localparam int unsigned PSL_A_BITS     = 26;
  localparam int unsigned PSL_C_BITS     = 50;
  localparam int unsigned PSL_EPS_BITS   = 48;
  localparam int unsigned PSL_DATA_BITS  = 64;
  localparam int unsigned PSL_ADDR_BITS  = 5;

  typedef enum logic [1:0] {
    REG_LINE_A  = 2'd0,
    REG_LINE_B  = 2'd1,
    REG_LINE_C  = 2'd2,
    REG_EPSILON = 2'd3
  } psl_reg_e;

  typedef struct packed {
    logic signed [PSL_A_BITS-1:0] line_a;
    logic signed [PSL_A_BITS-1:0] line_b;
    logic signed [PSL_C_BITS-1:0] line_c;
    logic [PSL_EPS_BITS-1:0]      epsilon;
  } psl_cfg_t;

  // Width of a signed line distance for a given coordinate width.
  function automatic int unsigned psl_dist_bits(int unsigned cb);
    int unsigned prod;
    prod = PSL_A_BITS + cb + 1;
    return ((prod > PSL_C_BITS) ? prod : PSL_C_BITS) + 1;
  endfunction

endpackage

FILE: design/psl_regs.sv
module psl_regs import psl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PSL_ADDR_BITS-1:0] paddr,
  input  logic [PSL_DATA_BITS-1:0] pwdata,
  output logic [PSL_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output psl_cfg_t                 cfg_o
);

  psl_cfg_t cfg_q;
  psl_reg_e sel;

  assign sel    = psl_reg_e'(paddr[4:3]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_LINE_A:  cfg_q.line_a  <= pwdata[PSL_A_BITS-1:0];
        REG_LINE_B:  cfg_q.line_b  <= pwdata[PSL_A_BITS-1:0];
        REG_LINE_C:  cfg_q.line_c  <= pwdata[PSL_C_BITS-1:0];
        REG_EPSILON: cfg_q.epsilon <= pwdata[PSL_EPS_BITS-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LINE_A:  prdata = PSL_DATA_BITS'(unsigned'(cfg_q.line_a));
      REG_LINE_B:  prdata = PSL_DATA_BITS'(unsigned'(cfg_q.line_b));
      REG_LINE_C:  prdata = PSL_DATA_BITS'(unsigned'(cfg_q.line_c));
      REG_EPSILON: prdata = PSL_DATA_BITS'(cfg_q.epsilon);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: design/psl_mac.sv
// Bit-serial dual multiply-accumulate: acc = b1*m1 + b2*m2 + init,
// multiplier bits taken MSB first, one bit per cycle.
module psl_mac import psl_pkg::*; #(
  parameter int unsigned COORD_BITS = PSL_COORD_BITS,
  localparam int unsigned DW = psl_dist_bits(COORD_BITS),
  localparam int unsigned NW = COORD_BITS + DW + 1,
  localparam int unsigned CW = $clog2(COORD_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [COORD_BITS-1:0]        bits1_i,
  input  logic [COORD_BITS-1:0]        bits2_i,
  input  logic signed [DW-1:0]         mult1_i,
  input  logic signed [DW-1:0]         mult2_i,
  input  logic signed [NW-1:0]         init_i,
  output logic                         done_o,
  output logic signed [NW-1:0]         acc_o
);

  logic                  busy_q, done_q;
  logic [CW-1:0]         cnt_q;
  logic [COORD_BITS-1:0] sh1_q, sh2_q;
  logic signed [DW-1:0]  m1_q, m2_q;
  logic signed [NW-1:0]  init_q, acc_q, t1, t2, acc_d;
  logic                  first, last;

  assign first  = (cnt_q == '0);
  assign last   = (cnt_q == CW'(COORD_BITS - 1));
  assign done_o = done_q;
  assign acc_o  = acc_q;

  always_comb begin
    // The sign bit carries negative weight.
    t1 = sh1_q[COORD_BITS-1] ? (first ? -NW'(m1_q) : NW'(m1_q)) : '0;
    t2 = sh2_q[COORD_BITS-1] ? (first ? -NW'(m2_q) : NW'(m2_q)) : '0;
    acc_d = (acc_q <<< 1) + t1 + t2 + (last ? init_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh1_q  <= bits1_i;
      sh2_q  <= bits2_i;
      m1_q   <= mult1_i;
      m2_q   <= mult2_i;
      init_q <= init_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      sh1_q <= sh1_q << 1;
      sh2_q <= sh2_q << 1;
      acc_q <= acc_d;
    end
  end

endmodule

FILE: design/psl_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// One extra leading step flags a quotient too wide for COORD_BITS bits;
// saturate the result to the signed COORD_BITS range then.
module psl_div import psl_pkg::*; #(
  parameter int unsigned COORD_BITS = PSL_COORD_BITS,
  localparam int unsigned DW = psl_dist_bits(COORD_BITS),
  localparam int unsigned NW = COORD_BITS + DW + 1,
  localparam int unsigned CW = $clog2(COORD_BITS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [NW-1:0]         num_i,
  input  logic signed [DW:0]           den_i,
  output logic                         done_o,
  output logic [COORD_BITS-1:0]        quo_o
);

  logic                  busy_q, done_q, neg_q, fit, big;
  logic [CW-1:0]         cnt_q;
  logic [NW-1:0]         rem_q, dsr_q, num_mag;
  logic [DW:0]           den_mag;
  logic [COORD_BITS:0]   quo_q;

  assign num_mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign den_mag = den_i[DW] ? (DW+1)'(-den_i) : (DW+1)'(den_i);
  assign fit     = (rem_q >= dsr_q);
  assign big     = quo_q[COORD_BITS] | quo_q[COORD_BITS-1];
  assign done_o  = done_q;
  assign quo_o   = neg_q ?
                   (big ? {1'b1, {(COORD_BITS-1){1'b0}}} : (-quo_q[COORD_BITS-1:0])) :
                   (big ? {1'b0, {(COORD_BITS-1){1'b1}}} : quo_q[COORD_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(COORD_BITS));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(COORD_BITS)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_mag;
      dsr_q <= NW'(den_mag) << COORD_BITS;
      neg_q <= num_i[NW-1] ^ den_i[DW];
      quo_q <= '0;
    end else if (busy_q) begin
      if (fit) rem_q <= rem_q - dsr_q;
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[COORD_BITS-1:0], fit};
    end
  end

endmodule

FILE: design/polygon_split_by_line.sv
// Polygon splitter against a configured line a*x + b*y + c.
// Input channel (in_valid_i/in_ready_o): one word per vertex. kind_i = 0
// primes the previous vertex with the polygon's last vertex and yields no
// result; kind_i = 1 classifies the vertex and yields one or two words.
// Output channel (out_valid_o/out_ready_i): an optional crossing point sent
// to both sides, then the vertex itself with last_of_run_o set.
// The block works on one word at a time. A word without crossing takes one
// serial distance pass through the shared multiply-accumulate; a crossing
// word takes two serial distance passes (new vertex, then previous vertex)
// and two serial numerator passes through the shared multiply-accumulate,
// and two serial divisions, in the order x numerator, x division, y
// numerator, y division, before its crossing point shows. No new word is
// taken until the block is through with the last one.
// A stalled receiver holds the result word in the output register; no new
// input is taken until every result of the word is gone.
// Reset clears the line registers to zero and the previous vertex to the
// origin, classed on the line. Registers are written over the APB port
// at byte address 8*index.
`include "polygon_split_by_line_defines.svh"

module polygon_split_by_line import psl_pkg::*; #(
  parameter int unsigned COORD_BITS = PSL_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PSL_ADDR_BITS-1:0]     paddr,
  input  logic [PSL_DATA_BITS-1:0]     pwdata,
  output logic [PSL_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         to_front_o,
  output logic                         to_back_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         is_crossing_o,
  output logic                         last_of_run_o,
  output logic                         polygon_done_o
);

  localparam int unsigned DW = psl_dist_bits(COORD_BITS);
  localparam int unsigned NW = COORD_BITS + DW + 1;

  // Side classes.
  localparam logic [1:0] SIDE_ON    = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DB   = 4'd1;  // distance of the new vertex
  localparam logic [3:0] S_DA   = 4'd2;  // distance of the previous vertex
  localparam logic [3:0] S_NX   = 4'd3;  // x numerator
  localparam logic [3:0] S_QX   = 4'd4;  // x division
  localparam logic [3:0] S_NY   = 4'd5;  // y numerator
  localparam logic [3:0] S_QY   = 4'd6;  // y division
  localparam logic [3:0] S_COUT = 4'd7;  // crossing word on output
  localparam logic [3:0] S_VOUT = 4'd8;  // vertex word on output

  psl_cfg_t cfg;

  logic [3:0]                  state_q, state_d;
  logic                        kind_q, last_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q, ix_q;
  logic [1:0]                  cur_side_q, prev_side_q, side_now;
  logic signed [DW-1:0]        db_q, da_q, dist_now, eps_ext;

  logic                        mac_start, mac_done;
  logic [COORD_BITS-1:0]       mac_b1, mac_b2;
  logic signed [DW-1:0]        mac_m1, mac_m2;
  logic signed [NW-1:0]        mac_init, mac_acc;

  logic                        div_start, div_done;
  logic signed [DW:0]          den;
  logic                        den_zero;
  logic [COORD_BITS-1:0]       div_quo;

  logic                        out_valid_q, to_front_q, to_back_q;
  logic                        cross_q, last_run_q, done_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                        crossing, load_vtx, load_cross;

  psl_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  psl_mac #(.COORD_BITS(COORD_BITS)) u_mac (
    .clk_i, .rst_ni, .start_i(mac_start), .bits1_i(mac_b1), .bits2_i(mac_b2),
    .mult1_i(mac_m1), .mult2_i(mac_m2), .init_i(mac_init),
    .done_o(mac_done), .acc_o(mac_acc)
  );

  psl_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mac_acc), .den_i(den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Classify the distance that the accumulator holds right now.
  assign dist_now = mac_acc[DW-1:0];
  assign eps_ext  = DW'(signed'({1'b0, cfg.epsilon}));
  always_comb begin
    if (dist_now > eps_ext)       side_now = SIDE_FRONT;
    else if (dist_now < -eps_ext) side_now = SIDE_BACK;
    else                          side_now = SIDE_ON;
  end

  assign crossing = (side_now == SIDE_FRONT && prev_side_q == SIDE_BACK) ||
                    (side_now == SIDE_BACK && prev_side_q == SIDE_FRONT);
  assign den = (DW+1)'(da_q) - (DW+1)'(db_q);
  // A zero divisor puts the crossing point on the previous vertex.
  assign den_zero = (den == '0);
  assign in_ready_o = (state_q == S_IDLE);

  // Operand select for the shared multiply-accumulate.
  always_comb begin
    mac_b1   = '0;
    mac_b2   = '0;
    mac_m1   = DW'(cfg.line_a);
    mac_m2   = DW'(cfg.line_b);
    mac_init = NW'(cfg.line_c);
    case (state_q)
      S_IDLE: begin
        mac_b1 = vertex_x_i;
        mac_b2 = vertex_y_i;
      end
      S_DB: begin
        mac_b1 = prev_x_q;
        mac_b2 = prev_y_q;
      end
      S_DA: begin
        mac_b1   = cur_x_q;
        mac_b2   = prev_x_q;
        mac_m1   = dist_now;
        mac_m2   = -db_q;
        mac_init = '0;
      end
      S_QX: begin
        mac_b1   = cur_y_q;
        mac_b2   = prev_y_q;
        mac_m1   = da_q;
        mac_m2   = -db_q;
        mac_init = '0;
      end
      default: begin
        mac_b1 = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    mac_start  = 1'b0;
    div_start  = 1'b0;
    load_vtx   = 1'b0;
    load_cross = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mac_start = 1'b1;
          state_d   = S_DB;
        end
      end
      S_DB: begin
        if (mac_done) begin
          if (!kind_q) begin
            state_d = S_IDLE;
          end else if (crossing) begin
            mac_start = 1'b1;
            state_d   = S_DA;
          end else begin
            load_vtx = 1'b1;
            state_d  = S_VOUT;
          end
        end
      end
      S_DA: begin
        if (mac_done) begin
          mac_start = 1'b1;
          state_d   = S_NX;
        end
      end
      S_NX: begin
        if (mac_done) begin
          div_start = 1'b1;
          state_d   = S_QX;
        end
      end
      S_QX: begin
        if (div_done) begin
          mac_start = 1'b1;
          state_d   = S_NY;
        end
      end
      S_NY: begin
        if (mac_done) begin
          div_start = 1'b1;
          state_d   = S_QY;
        end
      end
      S_QY: begin
        if (div_done) begin
          load_cross = 1'b1;
          state_d    = S_COUT;
        end
      end
      S_COUT: begin
        if (out_ready_i) begin
          load_vtx = 1'b1;
          state_d  = S_VOUT;
        end
      end
      S_VOUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_side_q <= SIDE_ON;
    end else begin
      state_q <= state_d;
      if (load_vtx || load_cross) out_valid_q <= 1'b1;
      else if (state_q == S_VOUT && out_ready_i) out_valid_q <= 1'b0;
      // Advance the previous vertex once this word is done with it; a priming
      // word takes its side straight from the classifier.
      if (state_q == S_DB && mac_done && !kind_q) begin
        prev_x_q    <= cur_x_q;
        prev_y_q    <= cur_y_q;
        prev_side_q <= side_now;
      end else if (state_q == S_VOUT && out_ready_i) begin
        prev_x_q    <= cur_x_q;
        prev_y_q    <= cur_y_q;
        prev_side_q <= cur_side_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      last_q  <= last_vertex_i;
      cur_x_q <= vertex_x_i;
      cur_y_q <= vertex_y_i;
    end
    if (state_q == S_DB && mac_done) begin
      db_q       <= dist_now;
      cur_side_q <= side_now;
    end
    if (state_q == S_DA && mac_done) da_q <= dist_now;
    if (state_q == S_QX && div_done) ix_q <= den_zero ? prev_x_q : div_quo;
    if (load_cross) begin
      to_front_q <= 1'b1;
      to_back_q  <= 1'b1;
      out_x_q    <= ix_q;
      out_y_q    <= den_zero ? prev_y_q : div_quo;
      cross_q    <= 1'b1;
      last_run_q <= 1'b0;
      done_q     <= 1'b0;
    end else if (load_vtx) begin
      // The side is in cur_side_q unless this is the first pass result.
      to_front_q <= (state_q == S_DB ? side_now : cur_side_q) != SIDE_BACK;
      to_back_q  <= (state_q == S_DB ? side_now : cur_side_q) != SIDE_FRONT;
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      cross_q    <= 1'b0;
      last_run_q <= 1'b1;
      done_q     <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign to_front_o     = to_front_q;
  assign to_back_o      = to_back_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign is_crossing_o  = cross_q;
  assign last_of_run_o  = last_run_q;
  assign polygon_done_o = done_q;

  `PSL_ASSERT_NOW(a_cross_both, !(out_valid_o && is_crossing_o) || (to_front_o && to_back_o && !last_of_run_o), "crossing word must go to both sides")
  `PSL_ASSERT_NOW(a_one_at_a_time, !(in_ready_o && out_valid_o), "input taken while a result is pending")
  `PSL_ASSERT_NEXT(a_vertex_follows, out_valid_o && is_crossing_o && out_ready_i, out_valid_o && !is_crossing_o && last_of_run_o, "vertex word must follow a crossing")

endmodule

FILE: dv/polygon_split_by_line_checker.sv
`timescale 1ns / 100ps

module polygon_split_by_line_checker import psl_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [PSL_ADDR_BITS-1:0]     paddr,
  input  logic [PSL_DATA_BITS-1:0]     pwdata,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         kind_i,
  input  logic signed [PSL_COORD_BITS-1:0] vertex_x_i,
  input  logic signed [PSL_COORD_BITS-1:0] vertex_y_i,
  input  logic                         last_vertex_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         to_front_i,
  input  logic                         to_back_i,
  input  logic signed [PSL_COORD_BITS-1:0] out_x_i,
  input  logic signed [PSL_COORD_BITS-1:0] out_y_i,
  input  logic                         is_crossing_i,
  input  logic                         last_of_run_i,
  input  logic                         polygon_done_i,
  output int                           errors_o,
  output int                           pending_o
);

  typedef enum logic [1:0] {SIDE_ON, SIDE_FRONT, SIDE_BACK} side_e;

  typedef struct packed {
    logic                          to_front;
    logic                          to_back;
    logic [PSL_COORD_BITS-1:0]     x;
    logic [PSL_COORD_BITS-1:0]     y;
    logic                          crossing;
    logic                          last_of_run;
    logic                          done;
  } point_t;

  logic signed [PSL_A_BITS-1:0] line_a, line_b;
  logic signed [PSL_C_BITS-1:0] line_c;
  logic [PSL_EPS_BITS-1:0]      eps;
  longint                       prev_x, prev_y;
  side_e                        prev_side;
  point_t                       split_q[$];
  int                           errors;

  assign errors_o  = errors;
  assign pending_o = split_q.size();

  function automatic longint line_dist(longint x, longint y);
    longint a, b, c;
    a = line_a;
    b = line_b;
    c = line_c;
    return a * x + b * y + c;
  endfunction

  function automatic side_e side_of(longint d);
    longint e;
    e = longint'(eps);
    if (d > e) return SIDE_FRONT;
    if (d < -e) return SIDE_BACK;
    return SIDE_ON;
  endfunction

  // (p*da - q*db) / (da - db), truncated toward zero, then clamped;
  // a zero divisor gives q
  function automatic logic [PSL_COORD_BITS-1:0] cut_coord(longint q, longint p,
                                                          longint da, longint db);
    logic signed [127:0] num, sub, den, quo;
    if (da == db) return q[PSL_COORD_BITS-1:0];
    num = p;
    num = num * da;
    sub = q;
    sub = sub * db;
    num = num - sub;
    den = da;
    den = den - db;
    quo = num / den;
    if (quo > 128'sd8388607) quo = 128'sd8388607;
    if (quo < -128'sd8388608) quo = -128'sd8388608;
    return quo[PSL_COORD_BITS-1:0];
  endfunction

  task automatic split_vertex();
    longint x, y, db, da;
    side_e  side;
    point_t pt;
    x = vertex_x_i;
    y = vertex_y_i;
    db = line_dist(x, y);
    side = side_of(db);
    if (kind_i) begin
      if ((side == SIDE_FRONT && prev_side == SIDE_BACK) ||
          (side == SIDE_BACK && prev_side == SIDE_FRONT)) begin
        da = line_dist(prev_x, prev_y);
        pt = '{1'b1, 1'b1, cut_coord(prev_x, x, da, db), cut_coord(prev_y, y, da, db),
               1'b1, 1'b0, 1'b0};
        split_q.push_back(pt);
      end
      pt = '{side != SIDE_BACK, side != SIDE_FRONT, vertex_x_i, vertex_y_i,
             1'b0, 1'b1, last_vertex_i};
      split_q.push_back(pt);
    end
    prev_x = x;
    prev_y = y;
    prev_side = side;
  endtask

  task automatic match_point();
    point_t exp_pt;
    if (split_q.size() == 0) begin
      $error("unexpected output word x=%0h y=%0h", out_x_i, out_y_i);
      errors++;
      return;
    end
    exp_pt = split_q.pop_front();
    if (to_front_i !== exp_pt.to_front) begin
      $error("to_front: expected %0h actual %0h", exp_pt.to_front, to_front_i);
      errors++;
    end
    if (to_back_i !== exp_pt.to_back) begin
      $error("to_back: expected %0h actual %0h", exp_pt.to_back, to_back_i);
      errors++;
    end
    if (out_x_i !== exp_pt.x) begin
      $error("out_x: expected %0h actual %0h", exp_pt.x, out_x_i);
      errors++;
    end
    if (out_y_i !== exp_pt.y) begin
      $error("out_y: expected %0h actual %0h", exp_pt.y, out_y_i);
      errors++;
    end
    if (is_crossing_i !== exp_pt.crossing) begin
      $error("is_crossing: expected %0h actual %0h", exp_pt.crossing, is_crossing_i);
      errors++;
    end
    if (last_of_run_i !== exp_pt.last_of_run) begin
      $error("last_of_run: expected %0h actual %0h", exp_pt.last_of_run, last_of_run_i);
      errors++;
    end
    if (polygon_done_i !== exp_pt.done) begin
      $error("polygon_done: expected %0h actual %0h", exp_pt.done, polygon_done_i);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_a = '0;
      line_b = '0;
      line_c = '0;
      eps = '0;
      prev_x = 0;
      prev_y = 0;
      prev_side = SIDE_ON;
      split_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (psl_reg_e'(paddr[4:3]))
          REG_LINE_A:  line_a = pwdata[PSL_A_BITS-1:0];
          REG_LINE_B:  line_b = pwdata[PSL_A_BITS-1:0];
          REG_LINE_C:  line_c = pwdata[PSL_C_BITS-1:0];
          REG_EPSILON: eps = pwdata[PSL_EPS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) split_vertex();
      if (out_valid_i && out_ready_i) match_point();
    end
  end

endmodule

FILE: dv/polygon_split_by_line_tb.sv
`timescale 1ns / 100ps

module polygon_split_by_line_tb;
  import psl_pkg::*;

  localparam int COORD_MAX  = 8388607;
  localparam int COORD_MIN  = -8388608;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE     = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PSL_ADDR_BITS-1:0] paddr = '0;
  logic [PSL_DATA_BITS-1:0] pwdata = '0;
  logic [PSL_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic kind_i = 1'b0, last_vertex_i = 1'b0;
  logic signed [PSL_COORD_BITS-1:0] vertex_x_i = '0, vertex_y_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic to_front_o, to_back_o, is_crossing_o, last_of_run_o, polygon_done_o;
  logic signed [PSL_COORD_BITS-1:0] out_x_o, out_y_o;

  int errors, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;   // toggle to start a long receiver hold-off
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  polygon_split_by_line dut (.*);

  polygon_split_by_line_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .vertex_x_i, .vertex_y_i,
    .last_vertex_i, .out_valid_i(out_valid_o), .out_ready_i, .to_front_i(to_front_o),
    .to_back_i(to_back_o), .out_x_i(out_x_o), .out_y_i(out_y_o),
    .is_crossing_i(is_crossing_o), .last_of_run_i(last_of_run_o),
    .polygon_done_i(polygon_done_o), .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write one line register: setup cycle, then access cycle.
  task automatic write_reg(psl_reg_e idx, longint value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PSL_ADDR_BITS'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_line(longint a, longint b, longint c, longint e);
    write_reg(REG_LINE_A, a);
    write_reg(REG_LINE_B, b);
    write_reg(REG_LINE_C, c);
    write_reg(REG_EPSILON, e);
  endtask

  // Offer one word; hold valid and payload until it is taken.
  task automatic send_word(logic kind, int x, int y, logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    vertex_x_i <= PSL_COORD_BITS'(x);
    vertex_y_i <= PSL_COORD_BITS'(y);
    last_vertex_i <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drop valid and let the block drain fully before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic int clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return int'(v);
  endfunction

  function automatic longint rand_coef();
    longint v;
    v = longint'($urandom_range(16777216)) >> $urandom_range(12);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom) >>> 8;
  endfunction

  // Random line through a random point, with a tolerance of varying size.
  task automatic random_line();
    longint a, b, c, e;
    int px, py;
    a = rand_coef();
    b = rand_coef();
    px = rand_coord() >>> $urandom_range(8);
    py = rand_coord() >>> $urandom_range(8);
    c = -(a * px + b * py);
    case ($urandom_range(3))
      0: e = 0;
      1: e = longint'($urandom_range(4096));
      2: e = (longint'($urandom) << 16) & 64'hffff_ffff_ffff;
      default: e = 64'hffff_ffff_ffff >> $urandom_range(47);
    endcase
    set_line(a, b, c, e);
  endtask

  // Random polygon around a center near the origin, primed with its last vertex.
  task automatic send_polygon(ref int words);
    int n, cx, cy, sh;
    int xs[8], ys[8];
    n = $urandom_range(3, 8);
    sh = $urandom_range(8, 23);
    cx = rand_coord() >>> $urandom_range(4, 23);
    cy = rand_coord() >>> $urandom_range(4, 23);
    for (int i = 0; i < n; i++) begin
      xs[i] = clamp_coord(longint'(cx) + (longint'(rand_coord()) >>> (23 - sh)));
      ys[i] = clamp_coord(longint'(cy) + (longint'(rand_coord()) >>> (23 - sh)));
    end
    send_word(1'b0, xs[n-1], ys[n-1], 1'($urandom_range(1)));
    for (int i = 0; i < n; i++) send_word(1'b1, xs[i], ys[i], i == n - 1);
    words += n + 1;
  endtask

  initial begin
    int words;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset line is all zero: every point is on the line and goes both ways.
    send_word(1'b1, COORD_MAX, COORD_MIN, 1'b0);
    send_word(1'b1, COORD_MIN, COORD_MAX, 1'b1);
    drain();

    // Vertical line x = 0, no tolerance.
    set_line(4096, 0, 0, 0);
    send_word(1'b1, COORD_MAX, 0, 1'b0);            // unprimed: previous is on line
    send_word(1'b1, COORD_MIN, COORD_MAX, 1'b0);    // front to back crossing
    send_word(1'b1, COORD_MAX, COORD_MIN, 1'b0);    // back to front crossing
    send_word(1'b1, 0, 12345, 1'b0);                // on the line
    send_word(1'b1, -1, -1, 1'b1);
    send_word(1'b0, 4096, 4096, 1'b1);              // prime; last flag ignored
    send_word(1'b1, -4096, 8192, 1'b0);
    send_word(1'b1, 4096, -8192, 1'b1);
    drain();

    // Extreme coefficients, wide tolerance and tight tolerance.
    set_line(16777216, -16777216, 48'h1_0000_0000_00 << 8, 64'hffff_ffff_ffff);
    send_word(1'b0, COORD_MIN, COORD_MIN, 1'b0);
    send_word(1'b1, COORD_MAX, COORD_MAX, 1'b0);
    send_word(1'b1, COORD_MAX, COORD_MIN, 1'b0);
    send_word(1'b1, COORD_MIN, COORD_MAX, 1'b1);
    drain();
    set_line(-16777216, 16777216, -(64'sd1 <<< 48), 1);
    send_word(1'b0, COORD_MAX, COORD_MIN, 1'b0);
    send_word(1'b1, COORD_MIN, COORD_MAX, 1'b0);
    send_word(1'b1, COORD_MAX, COORD_MIN, 1'b0);
    send_word(1'b1, 0, 0, 1'b1);
    drain();

    // Random phases cycling through the idling modes.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_line();
      words = 0;
      while (words < 200) begin
        if (phase == 4 && words > 50 && hold_left == 0 && hold_req == hold_seen &&
            words < 60)
          hold_req = ~hold_req;
        if ($urandom_range(99) < 85) begin
          send_polygon(words);
        end else begin
          // Noise: any kind, full-range coordinates, any last flag.
          send_word(1'($urandom_range(1)), int'($urandom) >>> 8, int'($urandom) >>> 8,
                    1'($urandom_range(1)));
          words++;
        end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/psl_pkg.sv
design/psl_regs.sv
design/psl_mac.sv
design/psl_div.sv
design/polygon_split_by_line.sv
dv/polygon_split_by_line_checker.sv
dv/polygon_split_by_line_tb.sv
